// ----- hw/rtl/scbd_pkg.sv -----
// shared constants, types and digit helpers for the signed bcd add/subtract/compare core
`default_nettype none

package scbd_pkg;

    // operand and stream geometry
    localparam int MAX_DIGITS = 16;
    localparam int DIGIT_W    = 4;
    localparam int MAG_W      = MAX_DIGITS * DIGIT_W;
    localparam int IN_BITS    = 3 + 2 * MAG_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = MAG_W + 6;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // input tdata field positions
    localparam int IN_CMD_LSB    = 0;
    localparam int IN_ASIGN_LSB  = 1;
    localparam int IN_ADIG_LSB   = 2;
    localparam int IN_BSIGN_LSB  = IN_ADIG_LSB + MAG_W;
    localparam int IN_BDIG_LSB   = IN_BSIGN_LSB + 1;

    // output tdata field positions
    localparam int OUT_SIGN_LSB    = MAG_W;
    localparam int OUT_CARRY_LSB   = MAG_W + 1;
    localparam int OUT_GREATER_LSB = MAG_W + 2;
    localparam int OUT_EQUAL_LSB   = MAG_W + 3;
    localparam int OUT_LESS_LSB    = MAG_W + 4;
    localparam int OUT_ZERO_LSB    = MAG_W + 5;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
    localparam logic [DIGIT_W:0]   RADIX     = 5'd10;

    typedef enum logic {
        CMD_ADD = 1'b0,
        CMD_SUB = 1'b1
    } t_cmd;

    typedef logic [DIGIT_W-1:0] t_digit;

    // comparison status handed from the comparator to the adder and output
    typedef struct packed {
        logic mag_lt;
        logic gt;
        logic eq;
        logic lt;
    } t_cmp_flags;

    // arithmetic result
    typedef struct packed {
        logic [MAG_W-1:0] digits;
        logic             sign;
        logic             carry_lost;
    } t_arith_res;

    // nibbles above nine read as nine
    function automatic t_digit clamp_digit(input t_digit d);
        return (d > DIGIT_MAX) ? DIGIT_MAX : d;
    endfunction

    // reduce a value below twenty to one decimal digit
    function automatic t_digit fold_ten(input logic [DIGIT_W:0] t);
        logic [DIGIT_W:0] m;
        m = t - RADIX;
        return (t >= RADIX) ? m[DIGIT_W-1:0] : t[DIGIT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/scbd_cmp.sv -----
// magnitude and signed comparison of the two bcd operands
`default_nettype none

module scbd_cmp #(
    parameter int NUM_DIGITS = scbd_pkg::MAX_DIGITS
) (
    input  wire logic                    i_a_sign,
    input  wire logic [scbd_pkg::MAG_W-1:0] i_a_digits,
    input  wire logic                    i_b_sign,
    input  wire logic [scbd_pkg::MAG_W-1:0] i_b_digits,
    output scbd_pkg::t_cmp_flags         o_flags
);
    import scbd_pkg::*;

    logic [NUM_DIGITS-1:0] gt_vec;
    logic [NUM_DIGITS-1:0] lt_vec;
    logic                  mag_gt;
    logic                  mag_lt;
    logic                  mag_eq;

    // per-digit greater and less marks
    for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_dig
        t_digit da;
        t_digit db;
        assign da        = clamp_digit(i_a_digits[i*DIGIT_W +: DIGIT_W]);
        assign db        = clamp_digit(i_b_digits[i*DIGIT_W +: DIGIT_W]);
        assign gt_vec[i] = (da > db);
        assign lt_vec[i] = (da < db);
    end

    // the highest differing digit decides, which a plain binary compare gives
    assign mag_gt = (gt_vec > lt_vec);
    assign mag_lt = (lt_vec > gt_vec);
    assign mag_eq = !mag_gt && !mag_lt;

    // signed ordering, plus zero above minus zero
    always_comb begin
        o_flags.mag_lt = mag_lt;
        o_flags.eq     = (i_a_sign == i_b_sign) && mag_eq;
        if (i_a_sign == i_b_sign) begin
            o_flags.gt = i_a_sign ? mag_lt : mag_gt;
        end else begin
            o_flags.gt = !i_a_sign;
        end
        o_flags.lt = !o_flags.gt && !o_flags.eq;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/scbd_addsub.sv -----
// sign-magnitude decimal add and subtract with lookahead carry and borrow
`default_nettype none

module scbd_addsub #(
    parameter int NUM_DIGITS = scbd_pkg::MAX_DIGITS
) (
    input  wire scbd_pkg::t_cmd            i_cmd,
    input  wire logic                      i_a_sign,
    input  wire logic [scbd_pkg::MAG_W-1:0] i_a_digits,
    input  wire logic                      i_b_sign,
    input  wire logic [scbd_pkg::MAG_W-1:0] i_b_digits,
    input  wire scbd_pkg::t_cmp_flags      i_flags,
    output scbd_pkg::t_arith_res           o_res
);
    import scbd_pkg::*;

    logic                  eff_b_sign;
    logic                  same_sign;
    logic [NUM_DIGITS-1:0] add_g;
    logic [NUM_DIGITS-1:0] add_p;
    logic [NUM_DIGITS-1:0] ab_g;
    logic [NUM_DIGITS-1:0] ba_g;
    logic [NUM_DIGITS-1:0] eq_p;
    logic [NUM_DIGITS:0]   add_sum;
    logic [NUM_DIGITS:0]   ab_sum;
    logic [NUM_DIGITS:0]   ba_sum;
    logic [NUM_DIGITS-1:0] add_cin;
    logic [NUM_DIGITS-1:0] ab_bin;
    logic [NUM_DIGITS-1:0] ba_bin;
    logic [MAG_W-1:0]      add_digits;
    logic [MAG_W-1:0]      ab_digits;
    logic [MAG_W-1:0]      ba_digits;

    assign eff_b_sign = i_b_sign ^ (i_cmd == CMD_SUB);
    assign same_sign  = (i_a_sign == eff_b_sign);

    // per-digit generate and propagate terms
    for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_gp
        t_digit           da;
        t_digit           db;
        logic [DIGIT_W:0] s;
        assign da       = clamp_digit(i_a_digits[i*DIGIT_W +: DIGIT_W]);
        assign db       = clamp_digit(i_b_digits[i*DIGIT_W +: DIGIT_W]);
        assign s        = {1'b0, da} + {1'b0, db};
        assign add_g[i] = (s >= RADIX);
        assign add_p[i] = (s == {1'b0, DIGIT_MAX});
        assign ab_g[i]  = (da < db);
        assign ba_g[i]  = (db < da);
        assign eq_p[i]  = (da == db);
    end

    // carry and borrow lookahead folded into one binary add each
    assign add_sum = {1'b0, add_g | add_p} + {1'b0, add_g};
    assign ab_sum  = {1'b0, ab_g | eq_p} + {1'b0, ab_g};
    assign ba_sum  = {1'b0, ba_g | eq_p} + {1'b0, ba_g};
    assign add_cin = add_sum[NUM_DIGITS-1:0] ^ add_p;
    assign ab_bin  = ab_sum[NUM_DIGITS-1:0] ^ eq_p;
    assign ba_bin  = ba_sum[NUM_DIGITS-1:0] ^ eq_p;

    // digit values for sum and both differences
    for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_dig
        t_digit da;
        t_digit db;
        assign da = clamp_digit(i_a_digits[i*DIGIT_W +: DIGIT_W]);
        assign db = clamp_digit(i_b_digits[i*DIGIT_W +: DIGIT_W]);
        assign add_digits[i*DIGIT_W +: DIGIT_W] =
            fold_ten({1'b0, da} + {1'b0, db} + {{DIGIT_W{1'b0}}, add_cin[i]});
        assign ab_digits[i*DIGIT_W +: DIGIT_W] =
            fold_ten({1'b0, da} + RADIX - {1'b0, db} - {{DIGIT_W{1'b0}}, ab_bin[i]});
        assign ba_digits[i*DIGIT_W +: DIGIT_W] =
            fold_ten({1'b0, db} + RADIX - {1'b0, da} - {{DIGIT_W{1'b0}}, ba_bin[i]});
    end

    // digits above the configured count stay zero
    if (NUM_DIGITS < MAX_DIGITS) begin : g_pad
        assign add_digits[MAG_W-1:NUM_DIGITS*DIGIT_W] = '0;
        assign ab_digits[MAG_W-1:NUM_DIGITS*DIGIT_W]  = '0;
        assign ba_digits[MAG_W-1:NUM_DIGITS*DIGIT_W]  = '0;
    end

    // pick the path; the larger magnitude sets the sign when signs differ
    always_comb begin
        if (same_sign) begin
            o_res.digits     = add_digits;
            o_res.sign       = i_a_sign;
            o_res.carry_lost = add_sum[NUM_DIGITS];
        end else if (i_flags.mag_lt) begin
            o_res.digits     = ba_digits;
            o_res.sign       = eff_b_sign;
            o_res.carry_lost = 1'b0;
        end else begin
            o_res.digits     = ab_digits;
            o_res.sign       = i_a_sign;
            o_res.carry_lost = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/signed_bcd_add_subtract_compare_core.sv -----
// top level: input register, add/subtract and compare logic, result register
//
//  channel  dir  tdata fields (lsb first)                              width
//  s_axis   in   cmd, a_sign, a_digits[64], b_sign, b_digits[64], pad   136
//  m_axis   out  result_digits[64], result_sign, carry_lost,             72
//                a_greater, a_equal, a_less, result_zero, pad
//
//  one transaction per cycle sustained while m_axis_tready stays high; the
//  operands pass through the input register, then the lookahead carry chain
//  and the digit compare, and the result is captured in the result register.
//  i_rst_n is synchronous, active low, and empties both registers.
//  a stall on m_axis holds the result; the input register still takes
//  one more transaction before s_axis_tready drops.
`default_nettype none

module signed_bcd_add_subtract_compare_core #(
    parameter int NUM_DIGITS = scbd_pkg::MAX_DIGITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // cmd, a_sign, a_digits, b_sign, b_digits, zero pad
    input  wire logic [scbd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // result_digits, result_sign, carry_lost, a_greater, a_equal, a_less,
    // result_zero, zero pad
    output logic [scbd_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import scbd_pkg::*;

    logic                  r_in_valid;
    logic                  n_in_valid;
    t_cmd                  r_cmd;
    logic                  r_a_sign;
    logic [MAG_W-1:0]      r_a_digits;
    logic                  r_b_sign;
    logic [MAG_W-1:0]      r_b_digits;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;
    logic                  in_take;
    logic                  in_adv;
    t_cmp_flags            flags;
    t_arith_res            res;

    // handshake: the input register drains whenever the result register frees
    assign in_adv        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || in_adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (in_adv) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (in_adv) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // operand capture
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd      <= t_cmd'(s_axis_tdata[IN_CMD_LSB]);
            r_a_sign   <= s_axis_tdata[IN_ASIGN_LSB];
            r_a_digits <= s_axis_tdata[IN_ADIG_LSB +: MAG_W];
            r_b_sign   <= s_axis_tdata[IN_BSIGN_LSB];
            r_b_digits <= s_axis_tdata[IN_BDIG_LSB +: MAG_W];
        end
    end

    scbd_cmp #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_cmp (
        .i_a_sign   (r_a_sign),
        .i_a_digits (r_a_digits),
        .i_b_sign   (r_b_sign),
        .i_b_digits (r_b_digits),
        .o_flags    (flags)
    );

    scbd_addsub #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_addsub (
        .i_cmd      (r_cmd),
        .i_a_sign   (r_a_sign),
        .i_a_digits (r_a_digits),
        .i_b_sign   (r_b_sign),
        .i_b_digits (r_b_digits),
        .i_flags    (flags),
        .o_res      (res)
    );

    // result packing
    always_comb begin
        n_out_data                  = '0;
        n_out_data[MAG_W-1:0]       = res.digits;
        n_out_data[OUT_SIGN_LSB]    = res.sign;
        n_out_data[OUT_CARRY_LSB]   = res.carry_lost;
        n_out_data[OUT_GREATER_LSB] = flags.gt;
        n_out_data[OUT_EQUAL_LSB]   = flags.eq;
        n_out_data[OUT_LESS_LSB]    = flags.lt;
        n_out_data[OUT_ZERO_LSB]    = (res.digits == '0);
    end

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ----- hw/rtl/scbd_chk.sv -----
// port-level checks on the core, attached by bind
`default_nettype none

module scbd_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic [scbd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [scbd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import scbd_pkg::*;

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // exactly one ordering flag
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot(m_axis_tdata[OUT_LESS_LSB:OUT_GREATER_LSB]))
        else $error("ordering flags not one-hot");

    // zero flag agrees with the digits
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[OUT_ZERO_LSB] == (m_axis_tdata[MAG_W-1:0] == '0)))
        else $error("zero flag mismatch");

    // an offered input transaction stays put until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("waiting input changed or dropped");

endmodule

bind signed_bcd_add_subtract_compare_core scbd_chk u_scbd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- tb/sv/signed_bcd_add_subtract_compare_checker.sv -----
// checker: predicts every result of the signed bcd core and compares it with the output stream
`timescale 1ns / 1ps

module signed_bcd_add_subtract_compare_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    input  wire logic                            i_s_tready,
    // cmd, a_sign, a_digits, b_sign, b_digits, zero pad
    input  wire logic [scbd_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  wire logic                            i_m_tvalid,
    input  wire logic                            i_m_tready,
    // result_digits, result_sign, carry_lost, a_greater, a_equal, a_less,
    // result_zero, zero pad
    input  wire logic [scbd_pkg::OUT_DATA_W-1:0] i_m_tdata,
    output int                                   o_mismatches,
    output int                                   o_outstanding,
    output int                                   o_checked,
    output int                                   o_carries,
    output int                                   o_minus_zeros
);
    import scbd_pkg::*;

    localparam int          DIGITS       = MAX_DIGITS;
    localparam int unsigned DECIMAL_BASE = 10;
    localparam int unsigned TOP_NIBBLE   = 9;
    localparam int          PRINT_CAP    = 50;

    // operands of one input transaction
    typedef struct packed {
        t_cmd             op;
        logic             a_neg;
        logic [MAG_W-1:0] a_mag;
        logic             b_neg;
        logic [MAG_W-1:0] b_mag;
    } t_bcd_operands;

    // fields of one output transaction
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             carry_out;
        logic             gt;
        logic             eq;
        logic             lt;
        logic             zero;
    } t_bcd_outcome;

    t_bcd_outcome  expected_sums[$];
    t_bcd_operands seen_ops;
    int            mismatch_count;
    int            checked_count;
    int            carry_count;
    int            minus_zero_count;
    int            pending_count;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = pending_count;
    assign o_checked     = checked_count;
    assign o_carries     = carry_count;
    assign o_minus_zeros = minus_zero_count;

    initial begin
        mismatch_count   = 0;
        checked_count    = 0;
        carry_count      = 0;
        minus_zero_count = 0;
        pending_count    = 0;
    end

    // one decimal digit, nibbles above nine read as nine
    function automatic int unsigned decimal_digit(input logic [MAG_W-1:0] m, input int idx);
        logic [DIGIT_W-1:0] nib;
        nib = m[idx*DIGIT_W +: DIGIT_W];
        return (nib > TOP_NIBBLE) ? TOP_NIBBLE : int'(nib);
    endfunction

    // signed-magnitude add or subtract plus the compare flags of a against b
    function automatic t_bcd_outcome predict_sum_and_order(input t_bcd_operands ops);
        t_bcd_outcome     r;
        logic             b_eff;
        int               order;
        int unsigned      x;
        int unsigned      y;
        int unsigned      s;
        int unsigned      carry;
        logic [MAG_W-1:0] big;
        logic [MAG_W-1:0] lit;
        r     = '0;
        order = 0;
        carry = 0;
        // magnitude order, most significant digit first
        for (int i = DIGITS - 1; i >= 0; i--) begin
            if (order == 0) begin
                x = decimal_digit(ops.a_mag, i);
                y = decimal_digit(ops.b_mag, i);
                if (x > y) order = 1;
                else if (x < y) order = -1;
            end
        end
        b_eff = ops.b_neg ^ (ops.op == CMD_SUB);
        if (ops.a_neg == b_eff) begin
            // same effective sign: add magnitudes with decimal carry
            r.neg = ops.a_neg;
            for (int i = 0; i < DIGITS; i++) begin
                s = decimal_digit(ops.a_mag, i) + decimal_digit(ops.b_mag, i) + carry;
                if (s >= DECIMAL_BASE) begin
                    s     = s - DECIMAL_BASE;
                    carry = 1;
                end else begin
                    carry = 0;
                end
                r.mag[i*DIGIT_W +: DIGIT_W] = 4'(s);
            end
            r.carry_out = (carry != 0);
        end else begin
            // differing signs: larger magnitude minus smaller, sign of the larger
            big   = ops.a_mag;
            lit   = ops.b_mag;
            r.neg = ops.a_neg;
            if (order < 0) begin
                big   = ops.b_mag;
                lit   = ops.a_mag;
                r.neg = b_eff;
            end
            for (int i = 0; i < DIGITS; i++) begin
                x = decimal_digit(big, i);
                y = decimal_digit(lit, i) + carry;
                if (x >= y) begin
                    s     = x - y;
                    carry = 0;
                end else begin
                    s     = x + DECIMAL_BASE - y;
                    carry = 1;
                end
                r.mag[i*DIGIT_W +: DIGIT_W] = 4'(s);
            end
        end
        // compare uses the original sign of b
        r.eq = (ops.a_neg == ops.b_neg) && (order == 0);
        if (ops.a_neg == ops.b_neg) begin
            r.gt = ops.a_neg ? (order < 0) : (order > 0);
        end else begin
            r.gt = !ops.a_neg;
        end
        r.lt   = !r.gt && !r.eq;
        r.zero = (r.mag == '0);
        return r;
    endfunction

    // one line per mismatch, printing capped
    task automatic report_mismatch(input string what, input logic [MAG_W-1:0] got,
                                   input logic [MAG_W-1:0] want);
        if (mismatch_count < PRINT_CAP) begin
            $display("%0t: mismatch on %s at result %0d: got %h want %h",
                     $time, what, checked_count, got, want);
        end
        mismatch_count++;
    endtask

    // compare one output transaction with the oldest prediction
    task automatic check_result(input logic [OUT_DATA_W-1:0] data);
        t_bcd_outcome want;
        if (expected_sums.size() == 0) begin
            report_mismatch("result with nothing pending", data[MAG_W-1:0], '0);
            return;
        end
        want = expected_sums.pop_front();
        if (data[MAG_W-1:0] !== want.mag)
            report_mismatch("result_digits", data[MAG_W-1:0], want.mag);
        if (data[OUT_SIGN_LSB] !== want.neg)
            report_mismatch("result_sign", data[OUT_SIGN_LSB], want.neg);
        if (data[OUT_CARRY_LSB] !== want.carry_out)
            report_mismatch("carry_lost", data[OUT_CARRY_LSB], want.carry_out);
        if (data[OUT_GREATER_LSB] !== want.gt)
            report_mismatch("a_greater", data[OUT_GREATER_LSB], want.gt);
        if (data[OUT_EQUAL_LSB] !== want.eq)
            report_mismatch("a_equal", data[OUT_EQUAL_LSB], want.eq);
        if (data[OUT_LESS_LSB] !== want.lt)
            report_mismatch("a_less", data[OUT_LESS_LSB], want.lt);
        if (data[OUT_ZERO_LSB] !== want.zero)
            report_mismatch("result_zero", data[OUT_ZERO_LSB], want.zero);
        if (data[OUT_DATA_W-1:OUT_ZERO_LSB+1] !== '0)
            report_mismatch("pad bits", data[OUT_DATA_W-1:OUT_ZERO_LSB+1], '0);
        if (want.carry_out) carry_count++;
        if (want.zero && want.neg) minus_zero_count++;
        checked_count++;
    endtask

    // watch both channels, results first so a stray one is never masked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) check_result(i_m_tdata);
            if (i_s_tvalid && i_s_tready) begin
                seen_ops.op    = t_cmd'(i_s_tdata[IN_CMD_LSB]);
                seen_ops.a_neg = i_s_tdata[IN_ASIGN_LSB];
                seen_ops.a_mag = i_s_tdata[IN_ADIG_LSB +: MAG_W];
                seen_ops.b_neg = i_s_tdata[IN_BSIGN_LSB];
                seen_ops.b_mag = i_s_tdata[IN_BDIG_LSB +: MAG_W];
                expected_sums.push_back(predict_sum_and_order(seen_ops));
            end
        end
        pending_count <= expected_sums.size();
    end

endmodule

// ----- tb/sv/signed_bcd_add_subtract_compare_core_tb.sv -----
// testbench top: clock, reset, stream stimulus and verdict for the signed bcd core
`timescale 1ns / 1ps

module signed_bcd_add_subtract_compare_core_tb;
    import scbd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 31;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int RESET_CYCLES = 5;
    localparam int DIGITS       = MAX_DIGITS;

    localparam logic [MAG_W-1:0] ALL_NINES = {MAX_DIGITS{4'h9}};
    localparam logic [MAG_W-1:0] ALL_F     = {MAX_DIGITS{4'hF}};
    localparam logic [MAG_W-1:0] TOP_ONE   = {4'h1, {(MAX_DIGITS-1){4'h0}}};

    logic                  clk;
    logic                  rst_n;
    logic                  s_valid;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data;
    logic                  m_valid;
    logic                  m_ready;
    logic [OUT_DATA_W-1:0] m_data;

    int mismatches;
    int outstanding;
    int checked;
    int carries;
    int minus_zeros;

    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_cycles;
    int cycle_count;
    int ops_sent;
    int dirty_ops;

    signed_bcd_add_subtract_compare_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data)
    );

    signed_bcd_add_subtract_compare_checker bcd_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_valid),
        .i_s_tready    (s_ready),
        .i_s_tdata     (s_data),
        .i_m_tvalid    (m_valid),
        .i_m_tready    (m_ready),
        .i_m_tdata     (m_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_carries     (carries),
        .o_minus_zeros (minus_zeros)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, outstanding);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold counted here
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles = rx_hold_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // offer one transaction after random gaps and wait for its handshake
    task automatic send_op(input t_cmd op, input logic a_neg, input logic [MAG_W-1:0] a_mag,
                           input logic b_neg, input logic [MAG_W-1:0] b_mag);
        logic [IN_DATA_W-1:0] word;
        logic                 dirty;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        word                             = '0;
        word[IN_CMD_LSB]                 = op;
        word[IN_ASIGN_LSB]               = a_neg;
        word[IN_ADIG_LSB +: MAG_W]       = a_mag;
        word[IN_BSIGN_LSB]               = b_neg;
        word[IN_BDIG_LSB +: MAG_W]       = b_mag;
        s_valid <= 1'b1;
        s_data  <= word;
        do @(posedge clk); while (!s_ready);
        dirty = 1'b0;
        for (int i = 0; i < DIGITS; i++) begin
            if (a_mag[i*DIGIT_W +: DIGIT_W] > 4'd9 || b_mag[i*DIGIT_W +: DIGIT_W] > 4'd9)
                dirty = 1'b1;
        end
        if (dirty) dirty_ops++;
        ops_sent++;
    endtask

    // sender stops and waits until every prediction has been matched
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // magnitude mix: mostly valid bcd of random length, some raw words, zeros and nines
    function automatic logic [MAG_W-1:0] random_magnitude();
        logic [MAG_W-1:0] m;
        int unsigned      len;
        m = '0;
        case ($urandom_range(0, 9))
            0, 1: m = {$urandom, $urandom};
            2: m = '0;
            3: begin
                m   = ALL_NINES;
                len = $urandom_range(0, 3);
                for (int i = 0; i < len; i++)
                    m[i*DIGIT_W +: DIGIT_W] = 4'($urandom_range(0, 9));
            end
            4, 5: begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    m[i*DIGIT_W +: DIGIT_W] = 4'($urandom_range(0, 9));
            end
            default: begin
                len = $urandom_range(1, DIGITS);
                for (int i = 0; i < len; i++)
                    m[i*DIGIT_W +: DIGIT_W] = 4'($urandom_range(0, 9));
            end
        endcase
        return m;
    endfunction

    // random operation: independent, equal or nearly equal magnitudes
    task automatic send_random_op();
        logic [MAG_W-1:0] am;
        logic [MAG_W-1:0] bm;
        am = random_magnitude();
        case ($urandom_range(0, 9))
            6, 7: bm = am;
            8, 9: begin
                bm = am;
                bm[$urandom_range(0, DIGITS-1)*DIGIT_W +: DIGIT_W] = 4'($urandom_range(0, 9));
            end
            default: bm = random_magnitude();
        endcase
        send_op(t_cmd'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), am,
                1'($urandom_range(0, 1)), bm);
    endtask

    // stimulus and verdict
    initial begin
        rst_n          <= 1'b0;
        s_valid        <= 1'b0;
        s_data         <= '0;
        tx_idle_pct    = IDLE_PCT;
        rx_idle_pct    = IDLE_PCT;
        rx_hold_cycles = 0;
        ops_sent       = 0;
        dirty_ops      = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zeros, signed zeros, top carries, borrows, invalid nibbles, ordering
        send_op(CMD_ADD, 1'b0, '0, 1'b0, '0);
        send_op(CMD_ADD, 1'b0, '0, 1'b1, '0);
        send_op(CMD_SUB, 1'b1, '0, 1'b1, '0);
        send_op(CMD_SUB, 1'b1, '0, 1'b0, '0);
        send_op(CMD_ADD, 1'b0, ALL_NINES, 1'b0, 64'h1);
        send_op(CMD_ADD, 1'b1, ALL_NINES, 1'b1, ALL_NINES);
        send_op(CMD_SUB, 1'b0, TOP_ONE, 1'b1, {4'h9, {(MAX_DIGITS-1){4'h0}}});
        send_op(CMD_ADD, 1'b0, 64'h123, 1'b1, 64'h123);
        send_op(CMD_ADD, 1'b1, 64'h123, 1'b0, 64'h123);
        send_op(CMD_SUB, 1'b0, 64'h5, 1'b0, 64'h5);
        send_op(CMD_SUB, 1'b0, 64'h3, 1'b0, 64'h8);
        send_op(CMD_SUB, 1'b0, TOP_ONE, 1'b0, 64'h1);
        send_op(CMD_ADD, 1'b0, {4'h0, {(MAX_DIGITS-1){4'h9}}}, 1'b0, 64'h1);
        send_op(CMD_SUB, 1'b0, 64'h2, 1'b1, 64'h3);
        send_op(CMD_ADD, 1'b0, 64'h1, 1'b1, 64'h100);
        send_op(CMD_ADD, 1'b1, 64'h100, 1'b0, 64'h1);
        send_op(CMD_ADD, 1'b1, 64'h5, 1'b1, 64'h7);
        send_op(CMD_SUB, 1'b1, 64'h7, 1'b1, 64'h5);
        send_op(CMD_ADD, 1'b0, ALL_F, 1'b0, '0);
        send_op(CMD_SUB, 1'b0, ALL_F, 1'b0, ALL_NINES);
        send_op(CMD_ADD, 1'b1, 64'hA0B0C0D0E0F01234, 1'b0, 64'h9090909090901234);
        send_op(CMD_SUB, 1'b1, ALL_F, 1'b1, ALL_F);
        wait_for_drain();

        // random with idling on both sides
        for (int n = 0; n < 800; n++) send_random_op();

        // back to back, no idling anywhere
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int n = 0; n < 400; n++) send_random_op();

        // long receiver hold while the sender keeps offering
        rx_idle_pct    = IDLE_PCT;
        rx_hold_cycles = HOLD_CYCLES;
        for (int n = 0; n < 200; n++) send_random_op();

        // random with idling again
        tx_idle_pct = IDLE_PCT;
        for (int n = 0; n < 600; n++) send_random_op();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d operations (%0d with nibbles above nine), %0d results checked",
                 ops_sent, dirty_ops, checked);
        $display("%0d top-digit carries dropped, %0d minus-zero results, %0d-cycle output hold",
                 carries, minus_zeros, HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/scbd_pkg.sv
hw/rtl/scbd_cmp.sv
hw/rtl/scbd_addsub.sv
hw/rtl/signed_bcd_add_subtract_compare_core.sv
hw/rtl/scbd_chk.sv
tb/sv/signed_bcd_add_subtract_compare_checker.sv
tb/sv/signed_bcd_add_subtract_compare_core_tb.sv
